FILE: rtl/etmm_pkg.sv
package etmm_pkg;

	// Default configuration
	localparam int SINE_TABLE_ENTRIES_DEF = 1024;
	localparam int FRAC_BITS_DEF          = 16;

	// Stream payload widths
	localparam int IN_W  = 240;
	localparam int OUT_W = 384;
	localparam int ANG_W = 16;
	localparam int VAL_W = 32;

	// Binary angle constants
	localparam logic [14:0] QUARTER_TURN = 15'd16384;
	localparam logic [15:0] QUARTER_PH   = 16'd16384;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// One quarter-wave sine entry from its Q30 argument, evaluated at elaboration.
	function automatic logic [63:0] sine_entry(input logic [63:0] x, input int frac);
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		for (int n = 1; n <= 11; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		v = (sum + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
		if (v < 0) begin
			v = 0;
		end
		if (v > (64'sd1 <<< frac)) begin
			v = 64'sd1 <<< frac;
		end
		return 64'(v);
	endfunction

endpackage

FILE: rtl/euler_trs_model_matrix.sv
// Channel  | Dir | Payload (tdata, lowest bits first)
// s_axis   | in  | pos_x pos_y pos_z angle_x angle_y angle_z scale_x scale_y scale_z
// m_axis   | out | m00 m01 m02 m10 m11 m12 m20 m21 m22 trans_x trans_y trans_z
//
// Five register stages: trig lookup, trig products, rotation sums,
// scale multiply, saturation into the output register. One pose per cycle
// unless stalled. arst_n clears the valid bits only. When the output holds
// a transfer that is not taken, the whole pipeline stops in place.
module euler_trs_model_matrix #(
	parameter int SINE_TABLE_ENTRIES = etmm_pkg::SINE_TABLE_ENTRIES_DEF,
	parameter int FRAC_BITS          = etmm_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z
	input  logic [etmm_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, trans_x, trans_y, trans_z
	output logic [etmm_pkg::OUT_W-1:0]  m_axis_tdata
);

	localparam int F   = FRAC_BITS;
	localparam int N   = SINE_TABLE_ENTRIES;
	localparam int IW  = $clog2(N + 1);
	localparam int PW  = 15 + IW + 1;
	localparam int TW  = F + 2;
	localparam int RW  = F + 3;
	localparam int SW  = RW + etmm_pkg::VAL_W;
	localparam int EW  = SW - F;
	localparam int VW  = etmm_pkg::VAL_W;

	// Quarter-wave sine table
	logic [F:0] sin_tab [0:N];
	for (genvar k = 0; k <= N; k++) begin : g_tab
		localparam logic [63:0] XK = (etmm_pkg::HALF_PI_Q30 * 64'(k)) / 64'(N);
		localparam logic [63:0] TK = etmm_pkg::sine_entry(XK, F);
		assign sin_tab[k] = TK[F:0];
	end

	// Rounded fixed-point product of two trig-range values
	function automatic logic signed [TW-1:0] fxm(input logic signed [TW-1:0] a,
			input logic signed [TW-1:0] b);
		logic signed [2*TW-1:0] p;
		p = (2*TW)'(a) * (2*TW)'(b) + ((2*TW)'(1) <<< (F - 1));
		return TW'(p >>> F);
	endfunction

	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: sine and cosine of all three angles
	logic signed [TW-1:0] sn [0:2];
	logic signed [TW-1:0] cs [0:2];
	for (genvar a = 0; a < 3; a++) begin : g_trig
		logic [15:0] us, uc;
		logic [14:0] ps, pc;
		logic [PW-1:0] qs, qc;
		logic [IW-1:0] is_, ic;
		assign us = s_axis_tdata[96 + 16*a +: 16];
		assign uc = us + etmm_pkg::QUARTER_PH;
		assign ps = us[14] ? etmm_pkg::QUARTER_TURN - {1'b0, us[13:0]} : {1'b0, us[13:0]};
		assign pc = uc[14] ? etmm_pkg::QUARTER_TURN - {1'b0, uc[13:0]} : {1'b0, uc[13:0]};
		assign qs = PW'(ps) * PW'(N) + PW'(8192);
		assign qc = PW'(pc) * PW'(N) + PW'(8192);
		assign is_ = qs[14 +: IW];
		assign ic  = qc[14 +: IW];
		assign sn[a] = us[15] ? -$signed(TW'(sin_tab[is_])) : $signed(TW'(sin_tab[is_]));
		assign cs[a] = uc[15] ? -$signed(TW'(sin_tab[ic])) : $signed(TW'(sin_tab[ic]));
	end

	logic                 v_s1;
	logic signed [TW-1:0] sa_s1, ca_s1, sb_s1, cb_s1, sc_s1, cc_s1;
	logic [95:0]          pos_s1, scl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s1  <= sn[0];
			ca_s1  <= cs[0];
			sb_s1  <= sn[1];
			cb_s1  <= cs[1];
			sc_s1  <= sn[2];
			cc_s1  <= cs[2];
			pos_s1 <= s_axis_tdata[95:0];
			scl_s1 <= s_axis_tdata[239:144];
		end
	end

	// Stage 2: pairwise trig products
	logic                 v_s2;
	logic signed [TW-1:0] sasb_s2, casb_s2, cbcc_s2, cbsc_s2, casc_s2, sacb_s2;
	logic signed [TW-1:0] cacb_s2, sasc_s2, sacc_s2, cacc_s2, sc_s2, cc_s2, sb_s2;
	logic [95:0]          pos_s2, scl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sasb_s2 <= fxm(sa_s1, sb_s1);
			casb_s2 <= fxm(ca_s1, sb_s1);
			cbcc_s2 <= fxm(cb_s1, cc_s1);
			cbsc_s2 <= fxm(cb_s1, sc_s1);
			casc_s2 <= fxm(ca_s1, sc_s1);
			sacb_s2 <= fxm(sa_s1, cb_s1);
			cacb_s2 <= fxm(ca_s1, cb_s1);
			sasc_s2 <= fxm(sa_s1, sc_s1);
			sacc_s2 <= fxm(sa_s1, cc_s1);
			cacc_s2 <= fxm(ca_s1, cc_s1);
			sc_s2   <= sc_s1;
			cc_s2   <= cc_s1;
			sb_s2   <= sb_s1;
			pos_s2  <= pos_s1;
			scl_s2  <= scl_s1;
		end
	end

	// Stage 3: rotation entries
	logic                 v_s3;
	logic signed [RW-1:0] r_s3 [0:8];
	logic [95:0]          pos_s3, scl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3[0] <= RW'(cbcc_s2);
			r_s3[1] <= -RW'(cbsc_s2);
			r_s3[2] <= RW'(sb_s2);
			r_s3[3] <= RW'(fxm(sasb_s2, cc_s2)) + RW'(casc_s2);
			r_s3[4] <= RW'(cacc_s2) - RW'(fxm(sasb_s2, sc_s2));
			r_s3[5] <= -RW'(sacb_s2);
			r_s3[6] <= RW'(sasc_s2) - RW'(fxm(casb_s2, cc_s2));
			r_s3[7] <= RW'(fxm(casb_s2, sc_s2)) + RW'(sacc_s2);
			r_s3[8] <= RW'(cacb_s2);
			pos_s3  <= pos_s2;
			scl_s3  <= scl_s2;
		end
	end

	// Stage 4: scale multiply with rounding
	logic                 v_s4;
	logic signed [EW-1:0] e_s4 [0:8];
	logic [95:0]          pos_s4;
	logic signed [SW-1:0] prod [0:8];

	for (genvar i = 0; i < 9; i++) begin : g_scl
		assign prod[i] = SW'(r_s3[i]) * SW'($signed(scl_s3[32*(i%3) +: 32]))
			+ (SW'(1) <<< (F - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				e_s4[i] <= EW'(prod[i] >>> F);
			end
			pos_s4 <= pos_s3;
		end
	end

	// Stage 5: saturation into the output register
	logic [VW*9-1:0] sat;
	for (genvar i = 0; i < 9; i++) begin : g_sat
		localparam logic signed [EW-1:0] MAXV = EW'({1'b0, {(VW-1){1'b1}}});
		localparam logic signed [EW-1:0] MINV = -MAXV - EW'(1);
		assign sat[VW*i +: VW] = (e_s4[i] > MAXV) ? VW'(MAXV) :
			(e_s4[i] < MINV) ? VW'(MINV) : VW'(e_s4[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {pos_s4, sat};
		end
	end

endmodule

FILE: tb/euler_trs_model_matrix_test.sv
module euler_trs_model_matrix_test;

	localparam int ENTRIES = etmm_pkg::SINE_TABLE_ENTRIES_DEF;
	localparam int FB      = etmm_pkg::FRAC_BITS_DEF;
	localparam int N_RAND  = 800;
	localparam int LIMIT   = 400000;

	typedef struct packed {
		logic [31:0] scale_z, scale_y, scale_x;
		logic [15:0] angle_z, angle_y, angle_x;
		logic [31:0] pos_z, pos_y, pos_x;
	} pose_t;

	typedef struct packed {
		logic [31:0] trans_z, trans_y, trans_x;
		logic [31:0] m22, m21, m20, m12, m11, m10, m02, m01, m00;
	} matrix_t;

	// One row of the directed table; check_lit marks rows with a literal result
	typedef struct {
		pose_t   pose;
		bit      check_lit;
		matrix_t lit;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [etmm_pkg::IN_W-1:0]  s_axis_tdata;  // pos_x, pos_y, pos_z, angle_x..z, scale_x..z
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [etmm_pkg::OUT_W-1:0] m_axis_tdata;  // m00..m22, trans_x, trans_y, trans_z

	euler_trs_model_matrix u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	longint    sine_quarter[ENTRIES+1];
	matrix_t   pending_mats[$];
	int        n_errors;
	int        cycle_cnt;
	bit        calm;
	bit        sending_done;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Quarter-wave sine table, Taylor series in Q30
	task automatic build_sine_quarter();
		longint unsigned x, x2, term;
		longint sum, v;
		for (int k = 0; k <= ENTRIES; k++) begin
			x = (64'd1686629713 * k) / ENTRIES;
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 11; n++) begin
				term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
				if (n % 2) sum -= term;
				else sum += term;
			end
			v = (sum + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
			if (v < 0) v = 0;
			if (v > (64'sd1 <<< FB)) v = 64'sd1 <<< FB;
			sine_quarter[k] = v;
		end
	endtask

	function automatic longint quarter_val(int p);
		longint idx;
		idx = (longint'(p) * ENTRIES + 8192) >>> 14;
		if (idx > ENTRIES) idx = ENTRIES;
		return sine_quarter[idx];
	endfunction

	function automatic longint phase_sin(logic [15:0] u);
		int r;
		r = int'(u[13:0]);
		case (u[15:14])
			2'd0: return quarter_val(r);
			2'd1: return quarter_val(16384 - r);
			2'd2: return -quarter_val(r);
			default: return -quarter_val(16384 - r);
		endcase
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b + (64'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	function automatic logic [31:0] sat_scaled(longint r, logic [31:0] s);
		longint v;
		v = qmul(r, longint'($signed(s)));
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	// Model matrix T*Rx*Ry*Rz*S for one pose
	function automatic matrix_t pose_matrix(pose_t p);
		longint sa, ca, sb, cb, sc, cc, sasb, casb;
		longint r[9];
		matrix_t m;
		sa = phase_sin(p.angle_x);
		ca = phase_sin(p.angle_x + 16'd16384);
		sb = phase_sin(p.angle_y);
		cb = phase_sin(p.angle_y + 16'd16384);
		sc = phase_sin(p.angle_z);
		cc = phase_sin(p.angle_z + 16'd16384);
		sasb = qmul(sa, sb);
		casb = qmul(ca, sb);
		r[0] = qmul(cb, cc);
		r[1] = -qmul(cb, sc);
		r[2] = sb;
		r[3] = qmul(sasb, cc) + qmul(ca, sc);
		r[4] = -qmul(sasb, sc) + qmul(ca, cc);
		r[5] = -qmul(sa, cb);
		r[6] = -qmul(casb, cc) + qmul(sa, sc);
		r[7] = qmul(casb, sc) + qmul(sa, cc);
		r[8] = qmul(ca, cb);
		m.m00 = sat_scaled(r[0], p.scale_x);
		m.m01 = sat_scaled(r[1], p.scale_y);
		m.m02 = sat_scaled(r[2], p.scale_z);
		m.m10 = sat_scaled(r[3], p.scale_x);
		m.m11 = sat_scaled(r[4], p.scale_y);
		m.m12 = sat_scaled(r[5], p.scale_z);
		m.m20 = sat_scaled(r[6], p.scale_x);
		m.m21 = sat_scaled(r[7], p.scale_y);
		m.m22 = sat_scaled(r[8], p.scale_z);
		m.trans_x = p.pos_x;
		m.trans_y = p.pos_y;
		m.trans_z = p.pos_z;
		return m;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_cnt);
		n_errors++;
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(0, 8)) - 4) <<< FB;
			3: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
		p.angle_x = 16'($urandom); p.angle_y = 16'($urandom); p.angle_z = 16'($urandom);
		if ($urandom_range(0, 3) == 0) p.angle_x[13:0] = '0;
		if ($urandom_range(0, 3) == 0) p.angle_y[13:0] = '0;
		p.scale_x = rand_val(); p.scale_y = rand_val(); p.scale_z = rand_val();
		return p;
	endfunction

	// Send one pose; waits for the transfer
	task automatic send_pose(pose_t p);
		while (!calm && $urandom_range(0, 99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= p;
		do @(posedge clk); while (!s_axis_tready);
		pending_mats.push_back(pose_matrix(p));
	endtask

	function automatic pose_t mk_pose(logic [31:0] px, py, pz, logic [15:0] ax, ay, az,
			logic [31:0] sx, sy, sz);
		pose_t p;
		p = '{sz, sy, sx, az, ay, ax, pz, py, px};
		return p;
	endfunction

	// Stimulus
	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		matrix_t ident;
		logic [31:0] one;
		one = 32'h00010000;
		ident = '0;
		ident.m00 = one; ident.m11 = one; ident.m22 = one;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		calm = 1'b0;
		sending_done = 1'b0;
		n_errors = 0;
		build_sine_quarter();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero pose, unit scale: identity rotation, literal check
		row.pose = mk_pose(0, 0, 0, 16'd0, 16'd0, 16'd0, one, one, one);
		row.check_lit = 1; row.lit = ident; rows.push_back(row);
		// Extreme positions pass through, zero scale gives zero rotation block
		row.pose = mk_pose(32'h7fffffff, 32'h80000000, 32'hffffffff, 16'd0, 16'd0, 16'd0,
			0, 0, 0);
		row.check_lit = 1; row.lit = '0;
		row.lit.trans_x = 32'h7fffffff; row.lit.trans_y = 32'h80000000;
		row.lit.trans_z = 32'hffffffff; rows.push_back(row);
		// Saturation at both limits with zero angles
		row.pose = mk_pose(0, 0, 0, 16'd0, 16'd0, 16'd0,
			32'h7fffffff, 32'h80000000, 32'h7fffffff);
		row.check_lit = 1; row.lit = '0;
		row.lit.m00 = 32'h7fffffff; row.lit.m11 = 32'h80000000; row.lit.m22 = 32'h7fffffff;
		rows.push_back(row);
		row.check_lit = 0;
		// Quadrant boundaries and angle extremes
		for (int a = 0; a < 4; a++) begin
			row.pose = mk_pose(1, 2, 3, 16'(a * 16384), 16'd0, 16'd0, one, one, one);
			rows.push_back(row);
			row.pose = mk_pose(1, 2, 3, 16'd0, 16'(a * 16384), 16'd0, one, one, one);
			rows.push_back(row);
			row.pose = mk_pose(1, 2, 3, 16'd0, 16'd0, 16'(a * 16384), one, one, one);
			rows.push_back(row);
		end
		row.pose = mk_pose(5, 6, 7, 16'h7fff, 16'h8000, 16'hffff, one, one, one);
		rows.push_back(row);
		row.pose = mk_pose(5, 6, 7, 16'h8000, 16'h7fff, 16'h0001,
			32'h80000000, 32'h80000000, 32'h80000000);
		rows.push_back(row);
		row.pose = mk_pose(5, 6, 7, 16'h2000, 16'h2000, 16'h2000,
			32'h7fffffff, 32'hffffffff, 32'h00000001);
		rows.push_back(row);
		row.pose = mk_pose(32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff,
			16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		rows.push_back(row);

		foreach (rows[i]) begin
			send_pose(rows[i].pose);
			if (rows[i].check_lit) pending_mats[$] = rows[i].lit;
		end

		// Hold off until the pipeline drains
		s_axis_tvalid <= 1'b0;
		while (pending_mats.size() != 0) @(posedge clk);

		for (int i = 0; i < N_RAND; i++) begin
			calm = (i >= 300 && i < 400);
			send_pose(rand_pose());
		end
		s_axis_tvalid <= 1'b0;
		sending_done = 1'b1;
	end

	// Sink side: random stalls, field checks
	initial begin
		matrix_t got, want;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pending_mats.size() == 0) begin
					report_mismatch("unexpected transfer", got.m00, 32'h0);
				end else begin
					want = pending_mats.pop_front();
					if (got.m00 !== want.m00) report_mismatch("m00", got.m00, want.m00);
					if (got.m01 !== want.m01) report_mismatch("m01", got.m01, want.m01);
					if (got.m02 !== want.m02) report_mismatch("m02", got.m02, want.m02);
					if (got.m10 !== want.m10) report_mismatch("m10", got.m10, want.m10);
					if (got.m11 !== want.m11) report_mismatch("m11", got.m11, want.m11);
					if (got.m12 !== want.m12) report_mismatch("m12", got.m12, want.m12);
					if (got.m20 !== want.m20) report_mismatch("m20", got.m20, want.m20);
					if (got.m21 !== want.m21) report_mismatch("m21", got.m21, want.m21);
					if (got.m22 !== want.m22) report_mismatch("m22", got.m22, want.m22);
					if (got.trans_x !== want.trans_x)
						report_mismatch("trans_x", got.trans_x, want.trans_x);
					if (got.trans_y !== want.trans_y)
						report_mismatch("trans_y", got.trans_y, want.trans_y);
					if (got.trans_z !== want.trans_z)
						report_mismatch("trans_z", got.trans_z, want.trans_z);
				end
			end
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);
		end
	end

	// Cycle counter, end of run and timeout
	initial begin
		int tail;
		cycle_cnt = 0;
		tail = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (sending_done && pending_mats.size() == 0) tail++;
			if (tail > 20) begin
				if (n_errors == 0) $display("ALL CHECKS PASSED");
				else $display("CHECKS FAILED");
				$finish;
			end else if (cycle_cnt > LIMIT) begin
				$display("timeout at cycle %0d", cycle_cnt);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end
endmodule

FILE: sim.f
rtl/etmm_pkg.sv
rtl/euler_trs_model_matrix.sv
tb/euler_trs_model_matrix_test.sv
